// ===== rtl/ehtp_pkg.sv =====
package ehtp_pkg;

   // Header sizes in bytes.
   localparam logic [15:0] ETH_HDR  = 16'd14;
   localparam logic [15:0] IPV4_HDR = 16'd20;
   localparam logic [15:0] IPV6_HDR = 16'd40;
   localparam logic [15:0] TCP_HDR  = 16'd20;
   localparam logic [3:0]  H2_HDR   = 4'd9;

   // Address offsets inside the IP header.
   localparam logic [15:0] IPV4_SRC_OFF = 16'd12;
   localparam logic [15:0] IPV4_DST_OFF = 16'd16;
   localparam logic [15:0] IPV6_SRC_OFF = 16'd8;
   localparam logic [15:0] IPV6_DST_OFF = 16'd24;
   localparam logic [15:0] IPV4_ADDR_LEN = 16'd4;
   localparam logic [15:0] IPV6_ADDR_LEN = 16'd16;

   // Byte positions of the EtherType and of fields inside the TCP header.
   localparam logic [15:0] ETYPE_HI_POS   = 16'd12;
   localparam logic [15:0] ETYPE_LO_POS   = 16'd13;
   localparam logic [15:0] TCP_SPORT_HI   = 16'd0;
   localparam logic [15:0] TCP_SPORT_LO   = 16'd1;
   localparam logic [15:0] TCP_DPORT_HI   = 16'd2;
   localparam logic [15:0] TCP_DPORT_LO   = 16'd3;
   localparam logic [15:0] TCP_DOFF_POS   = 16'd12;
   localparam logic [3:0]  TCP_DOFF_MIN   = 4'd5;

   localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
   localparam logic [7:0]  H2_TYPE_DATA = 8'h00;

   // Register map: word index of each configuration register.
   localparam logic CSR_NUMBERING_OFFSET = 1'b0;

   typedef enum logic [1:0] {
      IP_NONE = 2'd0,
      IP_V4   = 2'd1,
      IP_V6   = 2'd2
   } ip_kind_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_NOT_IP    = 3'd2;
   localparam logic [2:0] ST_NO_IP_HDR = 3'd3;
   localparam logic [2:0] ST_NO_TCP    = 3'd4;

   localparam logic REC_DATA   = 1'b0;
   localparam logic REC_STATUS = 1'b1;

   typedef struct packed {
      logic [31:0] frame_number;
      logic [63:0] src_addr_high;
      logic [63:0] src_addr_low;
      logic [63:0] dst_addr_high;
      logic [63:0] dst_addr_low;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [30:0] stream_id;
      logic [23:0] data_length;
      logic        record_kind;
      logic [2:0]  status;
      logic        frame_end;
   } rec_type;

endpackage

// ===== rtl/eth_ip_tcp_http2_header_parser_top.sv =====
// Path: an accepted byte is held in the input register, parsed there unless the result queue
// stalls it, and its results are written into the queue that offers them on the rsp channel.
// Throughput: one byte per cycle, also for a byte that makes two results; the four-entry
// result queue stalls req only while it holds more than two results.
// Reset: synchronous, active high; clears the frame and byte counters, the parse state,
// the queue pointers and the numbering offset. There is no clearing pass.
module eth_ip_tcp_http2_header_parser_top
   import ehtp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 65535
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_frame_number,
   output logic [63:0] rsp_src_addr_high,
   output logic [63:0] rsp_src_addr_low,
   output logic [63:0] rsp_dst_addr_high,
   output logic [63:0] rsp_dst_addr_low,
   output logic [15:0] rsp_src_port,
   output logic [15:0] rsp_dst_port,
   output logic [30:0] rsp_stream_id,
   output logic [23:0] rsp_data_length,
   output logic        rsp_record_kind,
   output logic [2:0]  rsp_status,
   output logic        rsp_frame_end,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [15:0] MAX_BYTES = 16'(MAX_FRAME_BYTES);

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;

   // Frame parse state.
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [7:0]        etype_hi_ff, etype_hi_in;
   ip_kind_type       kind_ff, kind_in;
   logic [63:0]       src_hi_ff, src_hi_in, src_lo_ff, src_lo_in;
   logic [63:0]       dst_hi_ff, dst_hi_in, dst_lo_ff, dst_lo_in;
   logic [15:0]       sport_ff, sport_in, dport_ff, dport_in;
   logic [7:0]        pstart_ff, pstart_in;
   logic [7:0]        hdr_ff [8];
   logic [3:0]        fill_ff, fill_in;
   logic [23:0]       skip_ff, skip_in;
   logic [31:0]       frames_ff, frames_in;
   logic [30:0]       offset_ff;

   // Result queue.
   rec_type           fifo_ff [4];
   logic [1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0]        count_ff, count_in;

   logic              proc, pop, in_range, is_v4, hdr_shift, has_data;
   logic [15:0]       p16, flen, t16, d16, iph;
   logic [15:0]       s_base, d_base, a_len, s_off, d_off;
   logic [7:0]        t8;
   logic [3:0]        doff;
   logic [2:0]        stat;
   logic [23:0]       h2_len;
   logic [30:0]       h2_sid;
   rec_type           data_rec, stat_rec;
   logic [1:0]        n_push;

   assign proc      = in_valid_ff && (count_ff <= 3'd2);
   assign req_ready = !in_valid_ff || proc;
   assign pop       = rsp_valid && rsp_ready;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   assign p16      = 16'(idx_ff);
   assign in_range = p16 < MAX_BYTES;

   always_comb begin
      idx_in      = idx_ff;
      etype_hi_in = etype_hi_ff;
      kind_in     = kind_ff;
      src_hi_in   = src_hi_ff;
      src_lo_in   = src_lo_ff;
      dst_hi_in   = dst_hi_ff;
      dst_lo_in   = dst_lo_ff;
      sport_in    = sport_ff;
      dport_in    = dport_ff;
      pstart_in   = pstart_ff;
      fill_in     = fill_ff;
      skip_in     = skip_ff;
      frames_in   = frames_ff;
      hdr_shift   = 1'b0;
      has_data    = 1'b0;
      is_v4       = 1'b0;
      t16         = '0;
      t8          = '0;
      d16         = '0;
      s_base      = '0;
      d_base      = '0;
      a_len       = '0;
      s_off       = '0;
      d_off       = '0;
      doff        = TCP_DOFF_MIN;
      h2_len      = {hdr_ff[0], hdr_ff[1], hdr_ff[2]};
      h2_sid      = {hdr_ff[5][6:0], hdr_ff[6], hdr_ff[7], in_byte_ff};

      if (proc && in_range) begin
         if (p16 == 16'd0) begin
            frames_in   = frames_ff + 32'd1;
            etype_hi_in = '0;
            kind_in     = IP_NONE;
            src_hi_in   = '0;
            src_lo_in   = '0;
            dst_hi_in   = '0;
            dst_lo_in   = '0;
            sport_in    = '0;
            dport_in    = '0;
            pstart_in   = '0;
            fill_in     = '0;
            skip_in     = '0;
         end
         if (p16 == ETYPE_HI_POS) begin
            etype_hi_in = in_byte_ff;
         end
         if (p16 == ETYPE_LO_POS) begin
            case ({etype_hi_ff, in_byte_ff})
               ETYPE_IPV4: kind_in = IP_V4;
               ETYPE_IPV6: kind_in = IP_V6;
               default:    kind_in = IP_NONE;
            endcase
         end

         if (kind_in != IP_NONE) begin
            is_v4  = (kind_in == IP_V4);
            s_base = ETH_HDR + (is_v4 ? IPV4_SRC_OFF : IPV6_SRC_OFF);
            d_base = ETH_HDR + (is_v4 ? IPV4_DST_OFF : IPV6_DST_OFF);
            a_len  = is_v4 ? IPV4_ADDR_LEN : IPV6_ADDR_LEN;
            s_off  = p16 - s_base;
            d_off  = p16 - d_base;
            // Address bytes land big-endian: byte k of a word sits at bits 63-8k.
            if (p16 >= s_base && s_off < a_len) begin
               if (!s_off[3]) src_hi_in[{~s_off[2:0], 3'b000} +: 8] = in_byte_ff;
               else           src_lo_in[{~s_off[2:0], 3'b000} +: 8] = in_byte_ff;
            end
            if (p16 >= d_base && d_off < a_len) begin
               if (!d_off[3]) dst_hi_in[{~d_off[2:0], 3'b000} +: 8] = in_byte_ff;
               else           dst_lo_in[{~d_off[2:0], 3'b000} +: 8] = in_byte_ff;
            end

            t16 = ETH_HDR + (is_v4 ? IPV4_HDR : IPV6_HDR);
            t8  = t16[7:0];
            d16 = p16 - t16;
            if (p16 >= t16 && d16 == TCP_SPORT_HI) sport_in[15:8] = in_byte_ff;
            if (p16 >= t16 && d16 == TCP_SPORT_LO) sport_in[7:0]  = in_byte_ff;
            if (p16 >= t16 && d16 == TCP_DPORT_HI) dport_in[15:8] = in_byte_ff;
            if (p16 >= t16 && d16 == TCP_DPORT_LO) dport_in[7:0]  = in_byte_ff;

            if (p16 >= t16 && d16 == TCP_DOFF_POS) begin
               doff      = (in_byte_ff[7:4] < TCP_DOFF_MIN) ? TCP_DOFF_MIN : in_byte_ff[7:4];
               pstart_in = t8 + {2'b00, doff, 2'b00};
            end else if (pstart_ff != 8'd0 && p16 >= 16'(pstart_ff)) begin
               if (skip_ff != 24'd0) begin
                  skip_in = skip_ff - 24'd1;
               end else begin
                  hdr_shift = 1'b1;
                  if (fill_ff == H2_HDR - 4'd1) begin
                     // Ninth header byte: the frame header is complete.
                     has_data = (hdr_ff[3] == H2_TYPE_DATA);
                     skip_in  = h2_len;
                     fill_in  = '0;
                  end else begin
                     fill_in = fill_ff + 4'd1;
                  end
               end
            end
         end
      end

      if (proc) begin
         if (in_last_ff)    idx_in = '0;
         else if (in_range) idx_in = idx_ff + IDX_W'(1);
      end
   end

   // End-of-frame status.
   always_comb begin
      flen = in_range ? p16 + 16'd1 : MAX_BYTES;
      iph  = (kind_in == IP_V4) ? IPV4_HDR : IPV6_HDR;
      if (flen < ETH_HDR)                          stat = ST_SHORT;
      else if (kind_in == IP_NONE)                 stat = ST_NOT_IP;
      else if (flen < ETH_HDR + iph)               stat = ST_NO_IP_HDR;
      else if (flen < ETH_HDR + iph + TCP_HDR)     stat = ST_NO_TCP;
      else                                         stat = ST_OK;
   end

   always_comb begin
      data_rec.frame_number  = frames_in + {1'b0, offset_ff};
      data_rec.src_addr_high = src_hi_in;
      data_rec.src_addr_low  = src_lo_in;
      data_rec.dst_addr_high = dst_hi_in;
      data_rec.dst_addr_low  = dst_lo_in;
      data_rec.src_port      = sport_in;
      data_rec.dst_port      = dport_in;
      data_rec.stream_id     = h2_sid;
      data_rec.data_length   = h2_len;
      data_rec.record_kind   = REC_DATA;
      data_rec.status        = ST_OK;
      data_rec.frame_end     = 1'b0;

      stat_rec.frame_number  = data_rec.frame_number;
      stat_rec.src_addr_high = (stat == ST_OK) ? src_hi_in : '0;
      stat_rec.src_addr_low  = (stat == ST_OK) ? src_lo_in : '0;
      stat_rec.dst_addr_high = (stat == ST_OK) ? dst_hi_in : '0;
      stat_rec.dst_addr_low  = (stat == ST_OK) ? dst_lo_in : '0;
      stat_rec.src_port      = (stat == ST_OK) ? sport_in : '0;
      stat_rec.dst_port      = (stat == ST_OK) ? dport_in : '0;
      stat_rec.stream_id     = '0;
      stat_rec.data_length   = '0;
      stat_rec.record_kind   = REC_STATUS;
      stat_rec.status        = stat;
      stat_rec.frame_end     = 1'b1;
   end

   always_comb begin
      n_push    = proc ? ({1'b0, has_data} + {1'b0, in_last_ff}) : 2'd0;
      wr_ptr_in = wr_ptr_ff + n_push;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, n_push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         idx_ff      <= '0;
         etype_hi_ff <= '0;
         kind_ff     <= IP_NONE;
         src_hi_ff   <= '0;
         src_lo_ff   <= '0;
         dst_hi_ff   <= '0;
         dst_lo_ff   <= '0;
         sport_ff    <= '0;
         dport_ff    <= '0;
         pstart_ff   <= '0;
         fill_ff     <= '0;
         skip_ff     <= '0;
         frames_ff   <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         offset_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         idx_ff      <= idx_in;
         etype_hi_ff <= etype_hi_in;
         kind_ff     <= kind_in;
         src_hi_ff   <= src_hi_in;
         src_lo_ff   <= src_lo_in;
         dst_hi_ff   <= dst_hi_in;
         dst_lo_ff   <= dst_lo_in;
         sport_ff    <= sport_in;
         dport_ff    <= dport_in;
         pstart_ff   <= pstart_in;
         fill_ff     <= fill_in;
         skip_ff     <= skip_in;
         frames_ff   <= frames_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         if (psel && penable && pwrite && paddr[2] == CSR_NUMBERING_OFFSET) begin
            offset_ff <= pwdata[30:0];
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (hdr_shift) begin
         for (int i = 0; i < 7; i++) begin
            hdr_ff[i] <= hdr_ff[i+1];
         end
         hdr_ff[7] <= in_byte_ff;
      end
      if (proc) begin
         if (has_data) begin
            fifo_ff[wr_ptr_ff] <= data_rec;
            if (in_last_ff) fifo_ff[wr_ptr_ff + 2'd1] <= stat_rec;
         end else if (in_last_ff) begin
            fifo_ff[wr_ptr_ff] <= stat_rec;
         end
      end
   end

   assign rsp_valid         = (count_ff != 3'd0);
   assign rsp_frame_number  = fifo_ff[rd_ptr_ff].frame_number;
   assign rsp_src_addr_high = fifo_ff[rd_ptr_ff].src_addr_high;
   assign rsp_src_addr_low  = fifo_ff[rd_ptr_ff].src_addr_low;
   assign rsp_dst_addr_high = fifo_ff[rd_ptr_ff].dst_addr_high;
   assign rsp_dst_addr_low  = fifo_ff[rd_ptr_ff].dst_addr_low;
   assign rsp_src_port      = fifo_ff[rd_ptr_ff].src_port;
   assign rsp_dst_port      = fifo_ff[rd_ptr_ff].dst_port;
   assign rsp_stream_id     = fifo_ff[rd_ptr_ff].stream_id;
   assign rsp_data_length   = fifo_ff[rd_ptr_ff].data_length;
   assign rsp_record_kind   = fifo_ff[rd_ptr_ff].record_kind;
   assign rsp_status        = fifo_ff[rd_ptr_ff].status;
   assign rsp_frame_end     = fifo_ff[rd_ptr_ff].frame_end;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_NUMBERING_OFFSET) ? {1'b0, offset_ff} : 32'd0;

endmodule

// ===== rtl/ehtp_checker.sv =====
module ehtp_checker
   import ehtp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_frame_number,
   input logic [63:0] rsp_src_addr_high,
   input logic [63:0] rsp_src_addr_low,
   input logic [63:0] rsp_dst_addr_high,
   input logic [63:0] rsp_dst_addr_low,
   input logic [15:0] rsp_src_port,
   input logic [15:0] rsp_dst_port,
   input logic [30:0] rsp_stream_id,
   input logic [23:0] rsp_data_length,
   input logic        rsp_record_kind,
   input logic [2:0]  rsp_status,
   input logic        rsp_frame_end
);

   // A stalled result item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_number)
         && $stable(rsp_stream_id) && $stable(rsp_record_kind) && $stable(rsp_status))
      else $error("result item changed while stalled");

   // A DATA record never carries an error or the end-of-frame mark.
   a_data_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == REC_DATA |-> rsp_status == ST_OK && !rsp_frame_end)
      else $error("DATA record with status or frame end");

   // A status record always ends the frame and has no HTTP/2 fields.
   a_stat_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == REC_STATUS |->
         rsp_frame_end && rsp_stream_id == 31'd0 && rsp_data_length == 24'd0)
      else $error("malformed status record");

   // A failed frame reports no endpoints.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == REC_STATUS && rsp_status != ST_OK |->
         rsp_src_addr_high == 64'd0 && rsp_src_addr_low == 64'd0
         && rsp_dst_addr_high == 64'd0 && rsp_dst_addr_low == 64'd0
         && rsp_src_port == 16'd0 && rsp_dst_port == 16'd0)
      else $error("endpoints reported for a failed frame");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_NO_TCP)
      else $error("status code out of range");

endmodule

bind eth_ip_tcp_http2_header_parser_top ehtp_checker u_ehtp_checker (.*);

// ===== dv/parser_record_checker.sv =====
`timescale 1ns / 100ps

// Watches the byte channel, the register port and the record channel of the
// header parser. It keeps its own copy of the parse state and predicts the
// records that each accepted byte causes.
module parser_record_checker
   import ehtp_pkg::*;
#(
   parameter int         MAX_FRAME_BYTES = 65535,
   parameter logic [2:0] OFFSET_ADDR     = 3'd0
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_frame_number,
   input  logic [63:0] rsp_src_addr_high,
   input  logic [63:0] rsp_src_addr_low,
   input  logic [63:0] rsp_dst_addr_high,
   input  logic [63:0] rsp_dst_addr_low,
   input  logic [15:0] rsp_src_port,
   input  logic [15:0] rsp_dst_port,
   input  logic [30:0] rsp_stream_id,
   input  logic [23:0] rsp_data_length,
   input  logic        rsp_record_kind,
   input  logic [2:0]  rsp_status,
   input  logic        rsp_frame_end,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,

   output int          records_pending,
   output int          mismatch_count
);

   rec_type     expected_records[$];

   logic [30:0] numbering;
   logic [31:0] frames_seen;
   logic [15:0] pos;
   logic [15:0] etype;
   ip_kind_type ipk;
   logic [63:0] src_w [2];
   logic [63:0] dst_w [2];
   logic [15:0] sport;
   logic [15:0] dport;
   logic [15:0] pay_start;
   logic [7:0]  h2_hdr [9];
   logic [3:0]  h2_fill;
   logic [23:0] skip_left;

   initial begin
      mismatch_count = 0;
      records_pending = 0;
   end

   function automatic logic [63:0] with_addr_byte(logic [63:0] word, logic [2:0] k,
                                                  logic [7:0] b);
      return word | (64'(b) << (8 * (7 - int'(k))));
   endfunction

   function automatic rec_type make_record(logic kind, logic [2:0] st, logic [30:0] sid,
                                           logic [23:0] len, logic fend, logic endpoints);
      rec_type r;
      r.frame_number  = frames_seen + {1'b0, numbering};
      r.src_addr_high = endpoints ? src_w[0] : 64'd0;
      r.src_addr_low  = endpoints ? src_w[1] : 64'd0;
      r.dst_addr_high = endpoints ? dst_w[0] : 64'd0;
      r.dst_addr_low  = endpoints ? dst_w[1] : 64'd0;
      r.src_port      = endpoints ? sport : 16'd0;
      r.dst_port      = endpoints ? dport : 16'd0;
      r.stream_id     = sid;
      r.data_length   = len;
      r.record_kind   = kind;
      r.status        = st;
      r.frame_end     = fend;
      return r;
   endfunction

   task automatic clear_frame();
      etype = '0;
      ipk = IP_NONE;
      src_w[0] = '0;
      src_w[1] = '0;
      dst_w[0] = '0;
      dst_w[1] = '0;
      sport = '0;
      dport = '0;
      pay_start = '0;
      h2_fill = '0;
      skip_left = '0;
   endtask

   task automatic parse_frame_byte(input logic [7:0] b, input logic last);
      logic        v4;
      logic [15:0] src_base;
      logic [15:0] dst_base;
      logic [15:0] alen;
      logic [15:0] rel;
      logic [15:0] hdr_end;
      logic [15:0] ip_len;
      logic [3:0]  doff;
      logic [16:0] flen;
      logic [2:0]  st;
      logic [23:0] len;
      logic [30:0] sid;

      if (pos < MAX_FRAME_BYTES) begin
         if (pos == 0) begin
            frames_seen = frames_seen + 1;
            clear_frame();
         end
         if (pos == ETYPE_HI_POS) etype = {b, 8'h00};
         if (pos == ETYPE_LO_POS) begin
            etype[7:0] = b;
            if (etype == ETYPE_IPV4) ipk = IP_V4;
            else if (etype == ETYPE_IPV6) ipk = IP_V6;
            else ipk = IP_NONE;
         end
         if (ipk != IP_NONE) begin
            v4 = (ipk == IP_V4);
            src_base = ETH_HDR + (v4 ? IPV4_SRC_OFF : IPV6_SRC_OFF);
            dst_base = ETH_HDR + (v4 ? IPV4_DST_OFF : IPV6_DST_OFF);
            alen = v4 ? IPV4_ADDR_LEN : IPV6_ADDR_LEN;
            if (pos >= src_base && pos < src_base + alen) begin
               rel = pos - src_base;
               src_w[rel[3]] = with_addr_byte(src_w[rel[3]], rel[2:0], b);
            end
            if (pos >= dst_base && pos < dst_base + alen) begin
               rel = pos - dst_base;
               dst_w[rel[3]] = with_addr_byte(dst_w[rel[3]], rel[2:0], b);
            end

            hdr_end = ETH_HDR + (v4 ? IPV4_HDR : IPV6_HDR);
            if (pos == hdr_end + TCP_SPORT_HI) sport = {b, 8'h00};
            if (pos == hdr_end + TCP_SPORT_LO) sport[7:0] = b;
            if (pos == hdr_end + TCP_DPORT_HI) dport = {b, 8'h00};
            if (pos == hdr_end + TCP_DPORT_LO) dport[7:0] = b;
            if (pos == hdr_end + TCP_DOFF_POS) begin
               doff = b[7:4];
               if (doff < TCP_DOFF_MIN) doff = TCP_DOFF_MIN;
               pay_start = hdr_end + {10'd0, doff, 2'b00};
            end else if (pay_start != 0 && pos >= pay_start) begin
               if (skip_left != 0) begin
                  skip_left = skip_left - 1'b1;
               end else begin
                  h2_hdr[h2_fill] = b;
                  h2_fill = h2_fill + 1'b1;
                  if (h2_fill == H2_HDR) begin
                     len = {h2_hdr[0], h2_hdr[1], h2_hdr[2]};
                     sid = {h2_hdr[5][6:0], h2_hdr[6], h2_hdr[7], h2_hdr[8]};
                     if (h2_hdr[3] == H2_TYPE_DATA) begin
                        expected_records.push_back(
                           make_record(REC_DATA, ST_OK, sid, len, 1'b0, 1'b1));
                     end
                     skip_left = len;
                     h2_fill = '0;
                  end
               end
            end
         end
      end

      if (last) begin
         // Bytes past the frame size limit are not counted in the length.
         flen = (pos < MAX_FRAME_BYTES) ? 17'(pos) + 17'd1 : 17'(MAX_FRAME_BYTES);
         ip_len = (ipk == IP_V4) ? IPV4_HDR : IPV6_HDR;
         if (flen < ETH_HDR) st = ST_SHORT;
         else if (ipk == IP_NONE) st = ST_NOT_IP;
         else if (flen < ETH_HDR + ip_len) st = ST_NO_IP_HDR;
         else if (flen < ETH_HDR + ip_len + TCP_HDR) st = ST_NO_TCP;
         else st = ST_OK;
         expected_records.push_back(
            make_record(REC_STATUS, st, 31'd0, 24'd0, 1'b1, st == ST_OK));
         pos = '0;
      end else if (pos < MAX_FRAME_BYTES) begin
         pos = pos + 1'b1;
      end
   endtask

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rec_type want;
      if (reset) begin
         expected_records.delete();
         numbering = '0;
         frames_seen = '0;
         pos = '0;
         clear_frame();
      end else begin
         if (psel && penable && pwrite && pready && paddr == OFFSET_ADDR) begin
            numbering = pwdata[30:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_records.size() == 0) begin
               $error("record with nothing predicted: kind %0d, frame %0h",
                      rsp_record_kind, rsp_frame_number);
               mismatch_count++;
            end else begin
               want = expected_records.pop_front();
               check_field("frame_number", want.frame_number, rsp_frame_number);
               check_field("src_addr_high", want.src_addr_high, rsp_src_addr_high);
               check_field("src_addr_low", want.src_addr_low, rsp_src_addr_low);
               check_field("dst_addr_high", want.dst_addr_high, rsp_dst_addr_high);
               check_field("dst_addr_low", want.dst_addr_low, rsp_dst_addr_low);
               check_field("src_port", want.src_port, rsp_src_port);
               check_field("dst_port", want.dst_port, rsp_dst_port);
               check_field("stream_id", want.stream_id, rsp_stream_id);
               check_field("data_length", want.data_length, rsp_data_length);
               check_field("record_kind", want.record_kind, rsp_record_kind);
               check_field("status", want.status, rsp_status);
               check_field("frame_end", want.frame_end, rsp_frame_end);
            end
         end
         if (req_valid && req_ready) parse_frame_byte(req_data_byte, req_last_byte);
      end
      records_pending <= expected_records.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import ehtp_pkg::*;

   localparam int         FRAME_LIMIT = 65535;
   localparam logic [2:0] OFFSET_ADDR = {CSR_NUMBERING_OFFSET, 2'b00};

   logic        clock;
   logic        reset;

   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;

   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_frame_number;
   logic [63:0] rsp_src_addr_high;
   logic [63:0] rsp_src_addr_low;
   logic [63:0] rsp_dst_addr_high;
   logic [63:0] rsp_dst_addr_low;
   logic [15:0] rsp_src_port;
   logic [15:0] rsp_dst_port;
   logic [30:0] rsp_stream_id;
   logic [23:0] rsp_data_length;
   logic        rsp_record_kind;
   logic [2:0]  rsp_status;
   logic        rsp_frame_end;

   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int          records_pending;
   int          mismatch_count;

   logic [7:0]  frame_buf[$];
   int          bytes_sent;
   bit          gaps_on;
   bit          quiet;

   eth_ip_tcp_http2_header_parser_top #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_number  (rsp_frame_number),
      .rsp_src_addr_high (rsp_src_addr_high),
      .rsp_src_addr_low  (rsp_src_addr_low),
      .rsp_dst_addr_high (rsp_dst_addr_high),
      .rsp_dst_addr_low  (rsp_dst_addr_low),
      .rsp_src_port      (rsp_src_port),
      .rsp_dst_port      (rsp_dst_port),
      .rsp_stream_id     (rsp_stream_id),
      .rsp_data_length   (rsp_data_length),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_status        (rsp_status),
      .rsp_frame_end     (rsp_frame_end),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   parser_record_checker #(
      .MAX_FRAME_BYTES(FRAME_LIMIT),
      .OFFSET_ADDR    (OFFSET_ADDR)
   ) record_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_number  (rsp_frame_number),
      .rsp_src_addr_high (rsp_src_addr_high),
      .rsp_src_addr_low  (rsp_src_addr_low),
      .rsp_dst_addr_high (rsp_dst_addr_high),
      .rsp_dst_addr_low  (rsp_dst_addr_low),
      .rsp_src_port      (rsp_src_port),
      .rsp_dst_port      (rsp_dst_port),
      .rsp_stream_id     (rsp_stream_id),
      .rsp_data_length   (rsp_data_length),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_status        (rsp_status),
      .rsp_frame_end     (rsp_frame_end),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .records_pending   (records_pending),
      .mismatch_count    (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Record sink: ready in random bursts, with some long stretches of no stalls.
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat (($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 8)) @(posedge clock);
         if (!quiet && $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   function automatic void put_random(int n);
      for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
   endfunction

   function automatic void put_eth(logic [15:0] ethertype);
      put_random(12);
      frame_buf.push_back(ethertype[15:8]);
      frame_buf.push_back(ethertype[7:0]);
   endfunction

   function automatic void put_ip(logic v6);
      put_random(v6 ? int'(IPV6_HDR) : int'(IPV4_HDR));
   endfunction

   function automatic void put_tcp(logic [3:0] doff);
      int hdr_bytes;
      hdr_bytes = (doff < TCP_DOFF_MIN) ? int'(TCP_HDR) : 4 * int'(doff);
      put_random(int'(TCP_DOFF_POS));
      frame_buf.push_back({doff, 4'($urandom)});
      put_random(hdr_bytes - int'(TCP_DOFF_POS) - 1);
   endfunction

   function automatic void put_h2(logic [23:0] len, logic [7:0] kind, logic [31:0] sid,
                                  int body);
      frame_buf.push_back(len[23:16]);
      frame_buf.push_back(len[15:8]);
      frame_buf.push_back(len[7:0]);
      frame_buf.push_back(kind);
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(sid[31:24]);
      frame_buf.push_back(sid[23:16]);
      frame_buf.push_back(sid[15:8]);
      frame_buf.push_back(sid[7:0]);
      put_random(body);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Sends the first cut bytes of the built frame; the last one carries the end mark.
   task automatic send_frame(input int cut);
      for (int i = 0; i < cut; i++) send_byte(frame_buf[i], i == cut - 1);
      frame_buf.delete();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (records_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_offset(input logic [30:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= OFFSET_ADDR;
      pwdata <= {1'($urandom_range(0, 1)), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Mostly well-formed TCP frames carrying HTTP/2 frames; some are cut short
   // and some carry an EtherType that is not IP.
   task automatic random_frame();
      int          pick;
      int          cut;
      int          body;
      logic        v6;
      logic [3:0]  doff;
      logic [23:0] len;
      logic [7:0]  kind;
      logic [15:0] ethertype;

      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         case ($urandom_range(0, 4))
            0: ethertype = 16'h0801;
            1: ethertype = 16'h86DC;
            2: ethertype = 16'h08DD;
            3: ethertype = 16'h8600;
            default: ethertype = 16'($urandom);
         endcase
         put_eth(ethertype);
         put_random($urandom_range(0, 60));
         cut = $urandom_range(1, frame_buf.size());
      end else begin
         v6 = 1'($urandom_range(0, 1));
         put_eth(v6 ? ETYPE_IPV6 : ETYPE_IPV4);
         put_ip(v6);
         doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : TCP_DOFF_MIN;
         put_tcp(doff);
         for (int i = $urandom_range(0, 4); i > 0; i--) begin
            kind = ($urandom_range(0, 3) == 0) ? 8'($urandom) : H2_TYPE_DATA;
            len = 24'($urandom_range(0, 8));
            if ($urandom_range(0, 9) == 0) len = 24'($urandom);
            body = (len > 8) ? $urandom_range(0, 8) : int'(len);
            put_h2(len, kind, $urandom, body);
            // A long body runs past the end of the frame.
            if (len > 8) break;
         end
         cut = frame_buf.size();
         if (pick < 30) cut = $urandom_range(1, cut);
      end
      send_frame(cut);
   endtask

   initial begin
      logic [30:0] offsets [4];

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      bytes_sent = 0;
      gaps_on = 1'b1;
      quiet = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // One-byte frame of all ones, then a 13-byte frame of zeros.
      frame_buf.push_back(8'hFF);
      send_frame(1);
      for (int i = 0; i < 13; i++) frame_buf.push_back(8'h00);
      send_frame(13);
      // Not IP, ending right after the EtherType.
      put_eth(16'h86DC);
      send_frame(14);
      // IPv4 one byte short of a full IP header.
      put_eth(ETYPE_IPV4);
      put_ip(1'b0);
      send_frame(33);
      // IPv6 one byte short of a full TCP header.
      put_eth(ETYPE_IPV6);
      put_ip(1'b1);
      put_tcp(TCP_DOFF_MIN);
      send_frame(73);
      // Data offset below minimum, a non-DATA frame, then a DATA header that
      // ends on the frame's final byte with the reserved bit set.
      put_eth(ETYPE_IPV4);
      put_ip(1'b0);
      put_tcp(4'd0);
      put_h2(24'd2, 8'h01, 32'h0000_0001, 2);
      put_h2(24'd0, H2_TYPE_DATA, 32'hFFFF_FFFF, 0);
      send_frame(frame_buf.size());
      // Largest options and largest DATA length.
      put_eth(ETYPE_IPV6);
      put_ip(1'b1);
      put_tcp(4'd15);
      put_h2(24'hFF_FFFF, H2_TYPE_DATA, 32'h0000_0000, 3);
      send_frame(frame_buf.size());
      // TCP header runs past the end of the frame: no payload at all.
      put_eth(ETYPE_IPV4);
      put_ip(1'b0);
      put_tcp(4'd15);
      send_frame(64);
      drain();

      // Overlong frame: one DATA frame whose body reaches almost to the size
      // limit, then a header that straddles the limit and is never completed.
      gaps_on = 1'b0;
      put_eth(ETYPE_IPV4);
      put_ip(1'b0);
      put_tcp(TCP_DOFF_MIN);
      put_h2(24'd65467, H2_TYPE_DATA, $urandom, 65467);
      put_random(10);
      send_frame(frame_buf.size());
      drain();

      offsets[0] = 31'h7FFF_FFFF;
      offsets[1] = 31'($urandom);
      offsets[2] = 31'h0;
      offsets[3] = 31'($urandom);
      for (int phase = 0; phase < 4; phase++) begin
         write_offset(offsets[phase]);
         if (phase == 3) quiet = 1'b1;
         bytes_sent = 0;
         while (bytes_sent < 340) begin
            gaps_on = (phase != 3) && ($urandom_range(0, 2) != 0);
            random_frame();
         end
         drain();
      end

      if (mismatch_count == 0 && records_pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
